>>> sv/pott_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pott_pkg - shared types and codes for the periodic / one-shot timer table
// Command, status and result codes, the slot entry layout and the
// sequencer states.
// ---------------------------------------------------------------------------
package pott_pkg;

    // countdown and period width, in ticks
    localparam int CNT_W = 26;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // expiry results reported per tick, at most
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam int ID_W = 32;
    localparam int MS_W = 32;

    // command codes (mode field)
    typedef enum logic [1:0] {
        MODE_SET   = 2'd0,
        MODE_KILL  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    // status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // result kind
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // one slot as held in the entry memory
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] remain;
        logic             single;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_RESP,
        S_FLUSH
    } t_state;

endpackage

>>> sv/periodic_oneshot_timer_table_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_oneshot_timer_table_core - table of periodic / one-shot timers
// Set, kill, tick and clear commands against a table of SLOTS timers held
// in one synchronous entry memory, walked one slot per cycle unless stalled.
// ---------------------------------------------------------------------------
// Usage: each input beat carries one command (tuser = mode). Set, kill and
// clear return one status beat with tlast high. A tick decrements every
// live timer and returns one expiry beat per timer that reaches zero, in
// slot order, tlast on the final one, and no beat at all if none fires;
// at most 16 expiries are reported per tick, though every expired slot
// still reloads or frees. Periods are floored to whole ticks of TICK_MS,
// with a minimum of one tick and saturation at 2^26-1 ticks. Clear goes
// straight to its status; kill and tick walk the entry memory (one read
// port, one slot per cycle unless stalled, read data registered), and set
// first takes a divide step in which a reciprocal multiply turns
// milliseconds into ticks. A tick stalls mid-walk when a new expiry must
// go out while the output register is still full. Only one command is in
// flight at a time; the next is taken once the status or final expiry has
// been placed in the output register. Valid bits sit in flip-flops and
// reset empties the table at once, no clearing pass.
// ---------------------------------------------------------------------------
module periodic_oneshot_timer_table_core #(
    parameter int SLOTS   = 16,
    parameter int TICK_MS = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // [31:0] timer_id, [63:32] period_ms, [64] one_shot
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] fired_id, [33:32] status
    output logic [0:0]  o_m_tuser,   // [0] kind
    output logic        o_m_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // ms / TICK_MS as (ms * RCP) >> RCP_SH, exact for every 32-bit ms
    localparam int RCP_SH = pott_pkg::MS_W + $clog2(TICK_MS);
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << RCP_SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam logic [pott_pkg::MS_W:0] RCP = RCP_FULL[pott_pkg::MS_W:0];

    // ---------------------------------------------------------------- state
    pott_pkg::t_state r_state, n_state;

    // latched command
    pott_pkg::t_mode                  r_mode;
    logic [pott_pkg::ID_W-1:0]        r_id;
    logic                             r_single;

    // ms on accept, whole ticks after the divide step
    logic [pott_pkg::MS_W-1:0]        r_quo;

    // slot walk
    logic [SLOTS-1:0]                 r_valid;
    logic                             r_iss;       // reads still to issue
    logic [IW-1:0]                    r_ridx;      // read address
    logic                             r_pv;        // read data in r_mem_q valid
    logic [IW-1:0]                    r_pidx;      // slot of r_mem_q

    // lookup results
    logic                             r_hit;
    logic [IW-1:0]                    r_hit_idx;
    logic                             r_free;
    logic [IW-1:0]                    r_free_idx;

    // held expiry (its tlast is unknown until the next one or the walk end)
    logic                             r_pend;
    logic [pott_pkg::ID_W-1:0]        r_pend_id;
    logic [pott_pkg::RES_CNT_W-1:0]   r_cnt;

    // entry memory
    pott_pkg::t_entry                 r_mem [SLOTS];
    pott_pkg::t_entry                 r_mem_q;

    // ----------------------------------------------------------- datapath
    logic [2*pott_pkg::MS_W:0]        rcp_prod;
    logic [2*pott_pkg::MS_W:0]        rcp_shr;
    logic [pott_pkg::MS_W-1:0]        div_q;
    logic [pott_pkg::CNT_W-1:0]       ticks;

    assign rcp_prod = {{(pott_pkg::MS_W+1){1'b0}}, r_quo} * {{pott_pkg::MS_W{1'b0}}, RCP};
    assign rcp_shr  = rcp_prod >> RCP_SH;
    assign div_q    = rcp_shr[pott_pkg::MS_W-1:0];

    always_comb begin
        if (|r_quo[pott_pkg::MS_W-1:pott_pkg::CNT_W]) begin
            ticks = pott_pkg::CNT_MAX;
        end else if (r_quo == '0) begin
            ticks = pott_pkg::CNT_W'(1);   // below one tick
        end else begin
            ticks = r_quo[pott_pkg::CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------ control
    logic                             out_free;
    logic                             in_acc;
    logic                             slot_live;
    logic                             fire;
    logic                             cap;
    logic                             adv;
    logic                             scan_end;
    logic                             resp_go;
    logic                             flush_go;
    logic                             set_ok;
    pott_pkg::t_status                resp_status;
    logic [IW-1:0]                    set_idx;

    logic                             wr_en;
    logic [IW-1:0]                    wr_addr;
    pott_pkg::t_entry                 wr_data;

    assign out_free = !o_m_tvalid || i_m_tready;
    assign in_acc   = i_s_tvalid && o_s_tready;

    // control outputs of the sequencer
    always_comb begin
        o_s_tready  = (r_state == pott_pkg::S_IDLE);
        slot_live   = r_pv && r_valid[r_pidx];
        fire        = (r_state == pott_pkg::S_SCAN) && (r_mode == pott_pkg::MODE_TICK)
                      && slot_live && (r_mem_q.remain <= pott_pkg::CNT_W'(1));
        cap         = fire && (r_cnt < pott_pkg::RES_CNT_W'(pott_pkg::MAX_RESULTS));
        adv         = !(cap && r_pend && !out_free);
        scan_end    = (r_state == pott_pkg::S_SCAN) && r_pv
                      && (r_pidx == IW'(SLOTS - 1)) && adv;
        resp_go     = (r_state == pott_pkg::S_RESP) && out_free;
        flush_go    = (r_state == pott_pkg::S_FLUSH) && out_free;
        set_ok      = r_hit || r_free;
        set_idx     = r_hit ? r_hit_idx : r_free_idx;

        unique case (r_mode)
            pott_pkg::MODE_SET:  resp_status = set_ok ? pott_pkg::ST_OK : pott_pkg::ST_FULL;
            pott_pkg::MODE_KILL: resp_status = r_hit ? pott_pkg::ST_OK : pott_pkg::ST_NOT_FOUND;
            default:             resp_status = pott_pkg::ST_OK;
        endcase

        wr_en   = 1'b0;
        wr_addr = r_pidx;
        wr_data = r_mem_q;
        if (r_state == pott_pkg::S_SCAN) begin
            wr_en          = adv && slot_live && (r_mode == pott_pkg::MODE_TICK)
                             && !(fire && r_mem_q.single);
            wr_data.remain = fire ? r_mem_q.period
                                  : r_mem_q.remain - pott_pkg::CNT_W'(1);
        end else if (r_state == pott_pkg::S_RESP) begin
            wr_en          = resp_go && (r_mode == pott_pkg::MODE_SET) && set_ok;
            wr_addr        = set_idx;
            wr_data.id     = r_id;
            wr_data.period = ticks;
            wr_data.remain = ticks;
            wr_data.single = r_single;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pott_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (pott_pkg::t_mode'(i_s_tuser))
                        pott_pkg::MODE_SET:   n_state = pott_pkg::S_DIV;
                        pott_pkg::MODE_CLEAR: n_state = pott_pkg::S_RESP;
                        default:              n_state = pott_pkg::S_SCAN;
                    endcase
                end
            end
            pott_pkg::S_DIV: begin
                n_state = pott_pkg::S_SCAN;
            end
            pott_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = (r_mode == pott_pkg::MODE_TICK) ? pott_pkg::S_FLUSH
                                                              : pott_pkg::S_RESP;
                end
            end
            pott_pkg::S_RESP: begin
                if (resp_go) begin
                    n_state = pott_pkg::S_IDLE;
                end
            end
            pott_pkg::S_FLUSH: begin
                if (!r_pend || out_free) begin
                    n_state = pott_pkg::S_IDLE;
                end
            end
            default: n_state = pott_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------ memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if ((r_state == pott_pkg::S_SCAN) && adv && r_iss) begin
            r_mem_q <= r_mem[r_ridx];
        end
    end

    // ---------------------------------------------------- command and divide
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= pott_pkg::t_mode'(i_s_tuser);
            r_id     <= i_s_tdata[31:0];
            r_quo    <= i_s_tdata[63:32];
            r_single <= i_s_tdata[64];
        end else if (r_state == pott_pkg::S_DIV) begin
            r_quo <= div_q;
        end
    end

    // ------------------------------------------------------ control regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pott_pkg::S_IDLE;
            r_valid    <= '0;
            r_iss      <= 1'b0;
            r_ridx     <= '0;
            r_pv       <= 1'b0;
            r_pidx     <= '0;
            r_hit      <= 1'b0;
            r_hit_idx  <= '0;
            r_free     <= 1'b0;
            r_free_idx <= '0;
            r_pend     <= 1'b0;
            r_pend_id  <= '0;
            r_cnt      <= '0;
            o_m_tvalid <= 1'b0;
            o_m_tdata  <= '0;
            o_m_tuser  <= '0;
            o_m_tlast  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (o_m_tvalid && i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end

            // arm the walk
            if (n_state == pott_pkg::S_SCAN && r_state != pott_pkg::S_SCAN) begin
                r_iss  <= 1'b1;
                r_ridx <= '0;
                r_pv   <= 1'b0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
                r_pend <= 1'b0;
                r_cnt  <= '0;
            end

            if (in_acc && (pott_pkg::t_mode'(i_s_tuser) == pott_pkg::MODE_CLEAR)) begin
                r_valid <= '0;
            end

            if (r_state == pott_pkg::S_SCAN && adv) begin
                // read pipeline
                r_pv   <= r_iss;
                r_pidx <= r_ridx;
                if (r_iss) begin
                    if (r_ridx == IW'(SLOTS - 1)) begin
                        r_iss <= 1'b0;
                    end else begin
                        r_ridx <= r_ridx + IW'(1);
                    end
                end

                // lookup of the id and of the lowest free slot
                if (slot_live && !r_hit && (r_mem_q.id == r_id)) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_pidx;
                end
                if (r_pv && !r_valid[r_pidx] && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_pidx;
                end

                // expiry: one-shot frees, held result goes out as not last
                if (fire && r_mem_q.single) begin
                    r_valid[r_pidx] <= 1'b0;
                end
                if (cap) begin
                    r_pend    <= 1'b1;
                    r_pend_id <= r_mem_q.id;
                    r_cnt     <= r_cnt + pott_pkg::RES_CNT_W'(1);
                    if (r_pend) begin
                        o_m_tvalid <= 1'b1;
                        o_m_tdata  <= {6'd0, pott_pkg::ST_OK, r_pend_id};
                        o_m_tuser  <= pott_pkg::KIND_EXPIRY;
                        o_m_tlast  <= 1'b0;
                    end
                end
            end

            if (resp_go) begin
                o_m_tvalid <= 1'b1;
                o_m_tdata  <= {6'd0, resp_status, {pott_pkg::ID_W{1'b0}}};
                o_m_tuser  <= pott_pkg::KIND_STATUS;
                o_m_tlast  <= 1'b1;
                if (r_mode == pott_pkg::MODE_SET && set_ok) begin
                    r_valid[set_idx] <= 1'b1;
                end
                if (r_mode == pott_pkg::MODE_KILL && r_hit) begin
                    r_valid[r_hit_idx] <= 1'b0;
                end
            end

            if (flush_go && r_pend) begin
                r_pend     <= 1'b0;
                o_m_tvalid <= 1'b1;
                o_m_tdata  <= {6'd0, pott_pkg::ST_OK, r_pend_id};
                o_m_tuser  <= pott_pkg::KIND_EXPIRY;
                o_m_tlast  <= 1'b1;
            end
        end
    end

    // --------------------------------------------------------- assertions
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0] == pott_pkg::KIND_STATUS) |-> o_m_tlast)
        else $error("status beat without tlast");

    a_status_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0] == pott_pkg::KIND_STATUS) |-> (o_m_tdata[31:0] == '0))
        else $error("status beat carries a timer id");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pott_pkg::RES_CNT_W'(pott_pkg::MAX_RESULTS))
        else $error("expiry count beyond cap");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == pott_pkg::S_SCAN || r_state == pott_pkg::S_FLUSH))
        else $error("held expiry outside a tick walk");

    a_walk_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv || r_iss) |-> (r_state == pott_pkg::S_SCAN))
        else $error("slot walk active outside scan");

endmodule
